// ----- sv/assert_macros.svh -----
// Assertion helpers used by the ledger engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked assertion, held off while reset is high.
`define PLG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked assertion that also runs during reset.
`define PLG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/plg_pkg.sv -----
`default_nettype none
package plg_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int QUEUE_DEPTH       = 2;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   // item class decided by the front
   typedef enum logic [1:0] {
      KIND_FILL,
      KIND_COST,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] key;
      logic        sell;
      logic [15:0] qty;
      logic [47:0] price;
      logic [23:0] mult;
      logic [31:0] comm;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } eng_stat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

// ----- sv/position_pnl_ledger.sv -----
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  operation, inst_key, side, quantity,
//                                          price, contract_multiplier, commission
// rsp      out        rsp_valid/rsp_ready  realized_total, cost_total, net_total,
//                                          unrealized_value, status
//
// Time from accept to rsp_valid depends on the path: a zero-quantity fill only adds its
// commission; a dropped fill or flat query runs the table sweep; an opening fill adds a
// table write; a query or closing fill adds two products; a same-side fill adds two products
// and the 82-step divider. The multiplier takes one bit per cycle.
// After reset a clearing pass over every table entry runs; req_ready stays low.
// A two-item queue lets requests be taken while the engine works or rsp stalls.
module position_pnl_ledger #(
   parameter int TABLE_ENTRIES = plg_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_operation,
   input  wire logic [31:0]         req_inst_key,
   input  wire logic                req_side,
   input  wire logic [15:0]         req_quantity,
   input  wire logic [47:0]         req_price,
   input  wire logic [23:0]         req_contract_multiplier,
   input  wire logic [31:0]         req_commission,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [63:0]       rsp_realized_total,
   output logic [62:0]              rsp_cost_total,
   output logic signed [63:0]       rsp_net_total,
   output logic signed [63:0]       rsp_unrealized_value,
   output logic [1:0]               rsp_status
);
   import plg_pkg::*;

   eng_stat_type   eng_stat;
   queue_stat_type q_stat;
   cmd_type        push_cmd, head_cmd;
   logic           push, pop;

   // classify and enqueue
   plg_front u_front (
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_operation           (req_operation),
      .req_inst_key            (req_inst_key),
      .req_side                (req_side),
      .req_quantity            (req_quantity),
      .req_price               (req_price),
      .req_contract_multiplier (req_contract_multiplier),
      .req_commission          (req_commission),
      .eng_stat_i              (eng_stat),
      .q_stat_i                (q_stat),
      .push_o                  (push),
      .cmd_o                   (push_cmd)
   );

   // item queue between front and engine
   plg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .cmd_i  (push_cmd),
      .pop_i  (pop),
      .cmd_o  (head_cmd),
      .stat_o (q_stat)
   );

   // table search, arithmetic and result register
   plg_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .cmd_i                (head_cmd),
      .q_stat_i             (q_stat),
      .pop_o                (pop),
      .stat_o               (eng_stat),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_realized_total   (rsp_realized_total),
      .rsp_cost_total       (rsp_cost_total),
      .rsp_net_total        (rsp_net_total),
      .rsp_unrealized_value (rsp_unrealized_value),
      .rsp_status           (rsp_status)
   );

endmodule
`default_nettype wire

// ----- sv/plg_front.sv -----
`default_nettype none
module plg_front (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [31:0]           req_inst_key,
   input  wire logic                  req_side,
   input  wire logic [15:0]           req_quantity,
   input  wire logic [47:0]           req_price,
   input  wire logic [23:0]           req_contract_multiplier,
   input  wire logic [31:0]           req_commission,
   input  wire plg_pkg::eng_stat_type eng_stat_i,
   input  wire plg_pkg::queue_stat_type q_stat_i,
   output logic                       push_o,
   output plg_pkg::cmd_type           cmd_o
);
   import plg_pkg::*;

   // no item taken while the table is being cleared
   assign req_ready = !q_stat_i.full && !eng_stat_i.clearing;
   assign push_o    = req_valid && req_ready;

   // classify: query, zero-quantity fill (cost only) or table fill
   always_comb begin
      if (req_operation) begin
         cmd_o.kind = KIND_QUERY;
      end else if (req_quantity == 16'd0) begin
         cmd_o.kind = KIND_COST;
      end else begin
         cmd_o.kind = KIND_FILL;
      end
      cmd_o.key   = req_inst_key;
      cmd_o.sell  = req_side;
      cmd_o.qty   = req_quantity;
      cmd_o.price = req_price;
      cmd_o.mult  = req_contract_multiplier;
      cmd_o.comm  = req_commission;
   end

endmodule
`default_nettype wire

// ----- sv/plg_queue.sv -----
`default_nettype none
module plg_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_i,
   input  wire plg_pkg::cmd_type       cmd_i,
   input  wire logic                   pop_i,
   output plg_pkg::cmd_type            cmd_o,
   output plg_pkg::queue_stat_type     stat_o
);
   import plg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   cnt_ff;

   assign stat_o.full  = (cnt_ff == DEPTH_C);
   assign stat_o.empty = (cnt_ff == '0);
   assign cmd_o        = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_i) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({push_i, pop_i})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= cmd_i;
      end
   end

endmodule
`default_nettype wire

// ----- sv/plg_engine.sv -----
`default_nettype none
`include "assert_macros.svh"
module plg_engine #(
   parameter int TABLE_ENTRIES = plg_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire plg_pkg::cmd_type       cmd_i,
   input  wire plg_pkg::queue_stat_type q_stat_i,
   output logic                        pop_o,
   output plg_pkg::eng_stat_type       stat_o,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [63:0]          rsp_realized_total,
   output logic [62:0]                 rsp_cost_total,
   output logic signed [63:0]          rsp_net_total,
   output logic signed [63:0]          rsp_unrealized_value,
   output logic [1:0]                  rsp_status
);
   import plg_pkg::*;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PROD_W = 104;
   localparam int SH_W   = PROD_W - 8;
   localparam int DIV_W  = 82;
   localparam logic [IDX_W:0] N_C    = (IDX_W + 1)'(TABLE_ENTRIES);
   localparam logic [IDX_W:0] LAST_C = (IDX_W + 1)'(TABLE_ENTRIES - 1);
   localparam logic [6:0] MUL_LAST = 7'd31;
   localparam logic [6:0] DIV_LAST = 7'(DIV_W - 1);
   localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] COST_MAX = '1;
   localparam logic [32:0] UNITS_MAX = 33'h0_7FFF_FFFF;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] units;
      logic [47:0] avg;
      logic [23:0] mult;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SEARCH, ST_DECIDE, ST_APPLY, ST_MUL,
      ST_MNEXT, ST_DIV, ST_WB, ST_COST, ST_FIN
   } state_type;

   typedef enum logic [1:0] {PH_PNL1, PH_PNL2, PH_AVG1, PH_AVG2} phase_type;

   state_type   state_ff;
   phase_type   phase_ff;
   cmd_type     cmd_ff;
   entry_type   mem [TABLE_ENTRIES];
   entry_type   rdata_ff;
   logic [IDX_W:0]   sidx_ff;
   logic             rvld_ff;
   logic [IDX_W-1:0] ridx_ff;
   logic             hit_ff, free_ff;
   logic [IDX_W-1:0] hit_idx_ff, free_idx_ff, eidx_ff;
   logic [31:0] hit_units_ff, u_ff;
   logic [47:0] hit_avg_ff, avg_ff;
   logic [23:0] hit_mult_ff, emult_ff;
   logic [PROD_W-1:0] mc_ff, pr_ff;
   logic [31:0] mp_ff, units2_ff;
   logic [6:0]  cnt_ff;
   logic        neg_ff;
   logic [32:0] den_ff, rem_ff;
   logic [DIV_W-1:0] num_ff;
   logic [47:0] quo_ff;
   logic [31:0] wb_units_ff;
   logic [47:0] wb_avg_ff;
   logic [23:0] wb_mult_ff;
   logic signed [63:0] realized_ff, unreal_ff;
   logic [62:0] cost_ff;
   logic        sat_ff, drop_ff;
   logic        rsp_valid_ff;
   logic signed [63:0] rsp_realized_ff, rsp_net_ff, rsp_unreal_ff;
   logic [62:0] rsp_cost_ff;
   logic [1:0]  rsp_status_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic              match, is_free;
   logic [31:0]       ua;
   logic [15:0]       closing;
   logic              same_side;
   logic [47:0]       diff;
   logic              neg_in;
   logic [SH_W-1:0]   sh;
   logic              term_ovf;
   logic [63:0]       lo, limit, mag, term;
   logic [64:0]       rsum;
   logic              radd_ovf;
   logic [63:0]       radd;
   logic [63:0]       csum;
   logic [64:0]       ndiff;
   logic              net_ovf;
   logic [63:0]       net;
   logic [32:0]       qs, nu, tot;
   logic [33:0]       rsh;
   logic              ge;
   logic [32:0]       rem_in;
   logic [47:0]       quo_in;

   assign pop_o           = (state_ff == ST_IDLE) && !q_stat_i.empty;
   assign stat_o.clearing = (state_ff == ST_CLEAR);

   // table memory: one write, one registered read
   assign mem_raddr = sidx_ff[IDX_W-1:0];
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = eidx_ff;
      mem_wdata = {1'b1, cmd_ff.key, wb_units_ff, wb_avg_ff, wb_mult_ff};
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sidx_ff[IDX_W-1:0];
         mem_wdata = '0;
      end else if (state_ff == ST_WB) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // search compare on the entry just read
   assign match   = rdata_ff.valid && (rdata_ff.key == cmd_ff.key);
   assign is_free = !rdata_ff.valid || (rdata_ff.units == '0);

   // position terms of the selected entry
   always_comb begin
      ua        = u_ff[31] ? (32'd0 - u_ff) : u_ff;
      closing   = (ua < {16'd0, cmd_ff.qty}) ? ua[15:0] : cmd_ff.qty;
      same_side = (u_ff[31] == cmd_ff.sell);
      qs        = cmd_ff.sell ? (33'd0 - {17'd0, cmd_ff.qty}) : {17'd0, cmd_ff.qty};
      nu        = {u_ff[31], u_ff} + qs;
      tot       = {1'b0, ua} + {17'd0, cmd_ff.qty};
   end

   // price difference against the entry (query uses the hit entry)
   always_comb begin
      logic [47:0] a;
      logic        s;
      a      = (state_ff == ST_DECIDE) ? hit_avg_ff : avg_ff;
      s      = (state_ff == ST_DECIDE) ? hit_units_ff[31] : u_ff[31];
      diff   = (cmd_ff.price >= a) ? (cmd_ff.price - a) : (a - cmd_ff.price);
      neg_in = (cmd_ff.price < a) != s;
   end

   // product to signed, saturated PnL term
   always_comb begin
      sh       = pr_ff[PROD_W-1:8];
      lo       = sh[63:0];
      limit    = neg_ff ? S_MIN : S_MAX;
      term_ovf = (|sh[SH_W-1:64]) || (lo > limit);
      mag      = term_ovf ? limit : lo;
      term     = neg_ff ? (64'd0 - mag) : mag;
   end

   // accumulator arithmetic
   always_comb begin
      rsum     = {realized_ff[63], realized_ff} + {term[63], term};
      radd_ovf = (rsum[64] != rsum[63]);
      radd     = radd_ovf ? (realized_ff[63] ? S_MIN : S_MAX) : rsum[63:0];
      csum     = {1'b0, cost_ff} + {32'd0, cmd_ff.comm};
      ndiff    = {realized_ff[63], realized_ff} - {2'b00, cost_ff};
      net_ovf  = (ndiff[64] != ndiff[63]);
      net      = net_ovf ? (realized_ff[63] ? S_MIN : S_MAX) : ndiff[63:0];
   end

   // one restoring division step
   always_comb begin
      rsh    = {rem_ff, num_ff[DIV_W-1]};
      ge     = (rsh >= {1'b0, den_ff});
      rem_in = ge ? 33'(rsh - {1'b0, den_ff}) : rsh[32:0];
      quo_in = {quo_ff[46:0], ge};
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sidx_ff      <= '0;
         rvld_ff      <= 1'b0;
         realized_ff  <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result in ST_FIN takes the register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               sidx_ff <= sidx_ff + 1'b1;
               if (sidx_ff == LAST_C) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!q_stat_i.empty) begin
                  cmd_ff    <= cmd_i;
                  sat_ff    <= 1'b0;
                  drop_ff   <= 1'b0;
                  unreal_ff <= '0;
                  hit_ff    <= 1'b0;
                  free_ff   <= 1'b0;
                  sidx_ff   <= '0;
                  rvld_ff   <= 1'b0;
                  state_ff  <= (cmd_i.kind == KIND_COST) ? ST_COST : ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (sidx_ff < N_C) begin
                  sidx_ff <= sidx_ff + 1'b1;
                  rvld_ff <= 1'b1;
                  ridx_ff <= sidx_ff[IDX_W-1:0];
               end else begin
                  rvld_ff <= 1'b0;
                  if (!rvld_ff) begin
                     state_ff <= ST_DECIDE;
                  end
               end
               if (rvld_ff) begin
                  if (match && !hit_ff) begin
                     hit_ff       <= 1'b1;
                     hit_idx_ff   <= ridx_ff;
                     hit_units_ff <= rdata_ff.units;
                     hit_avg_ff   <= rdata_ff.avg;
                     hit_mult_ff  <= rdata_ff.mult;
                  end
                  if (is_free && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= ridx_ff;
                  end
               end
            end
            ST_DECIDE: begin
               pr_ff  <= '0;
               cnt_ff <= '0;
               if (cmd_ff.kind == KIND_QUERY) begin
                  if (hit_ff && (hit_units_ff != '0)) begin
                     neg_ff    <= neg_in;
                     mc_ff     <= PROD_W'(diff);
                     mp_ff     <= {8'd0, hit_mult_ff};
                     units2_ff <= hit_units_ff[31] ? (32'd0 - hit_units_ff) : hit_units_ff;
                     phase_ff  <= PH_PNL1;
                     state_ff  <= ST_MUL;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end else if (!hit_ff && !free_ff) begin
                  drop_ff  <= 1'b1;
                  state_ff <= ST_FIN;
               end else begin
                  eidx_ff  <= hit_ff ? hit_idx_ff : free_idx_ff;
                  u_ff     <= hit_ff ? hit_units_ff : 32'd0;
                  avg_ff   <= hit_avg_ff;
                  emult_ff <= hit_mult_ff;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               priority if (u_ff == '0) begin
                  // open at the fill price
                  wb_units_ff <= qs[31:0];
                  wb_avg_ff   <= cmd_ff.price;
                  wb_mult_ff  <= cmd_ff.mult;
                  state_ff    <= ST_WB;
               end else if (same_side) begin
                  mc_ff    <= PROD_W'(avg_ff);
                  mp_ff    <= ua;
                  phase_ff <= PH_AVG1;
                  state_ff <= ST_MUL;
               end else begin
                  neg_ff    <= neg_in;
                  mc_ff     <= PROD_W'(diff);
                  mp_ff     <= {8'd0, emult_ff};
                  units2_ff <= {16'd0, closing};
                  phase_ff  <= PH_PNL1;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mp_ff[0]) begin
                  pr_ff <= pr_ff + mc_ff;
               end
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == MUL_LAST) begin
                  state_ff <= ST_MNEXT;
               end
            end
            ST_MNEXT: begin
               cnt_ff <= '0;
               unique case (phase_ff)
                  PH_PNL1: begin
                     mc_ff    <= pr_ff;
                     mp_ff    <= units2_ff;
                     pr_ff    <= '0;
                     phase_ff <= PH_PNL2;
                     state_ff <= ST_MUL;
                  end
                  PH_PNL2: begin
                     if (cmd_ff.kind == KIND_QUERY) begin
                        unreal_ff <= term;
                        sat_ff    <= sat_ff || term_ovf;
                        state_ff  <= ST_FIN;
                     end else begin
                        realized_ff <= radd;
                        sat_ff      <= sat_ff || term_ovf || radd_ovf;
                        wb_units_ff <= nu[31:0];
                        priority if (nu == '0) begin
                           wb_avg_ff  <= '0;
                           wb_mult_ff <= '0;
                        end else if (nu[32] != u_ff[31]) begin
                           wb_avg_ff  <= cmd_ff.price;
                           wb_mult_ff <= cmd_ff.mult;
                        end else begin
                           wb_avg_ff  <= avg_ff;
                           wb_mult_ff <= emult_ff;
                        end
                        state_ff <= ST_WB;
                     end
                  end
                  PH_AVG1: begin
                     mc_ff    <= PROD_W'(cmd_ff.price);
                     mp_ff    <= {16'd0, cmd_ff.qty};
                     phase_ff <= PH_AVG2;
                     state_ff <= ST_MUL;
                  end
                  PH_AVG2: begin
                     num_ff   <= pr_ff[DIV_W-1:0];
                     den_ff   <= tot;
                     rem_ff   <= '0;
                     quo_ff   <= '0;
                     state_ff <= ST_DIV;
                  end
                  default: state_ff <= ST_FIN;
               endcase
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_LAST) begin
                  wb_avg_ff  <= quo_in;
                  wb_mult_ff <= emult_ff;
                  if (tot > UNITS_MAX) begin
                     sat_ff      <= 1'b1;
                     wb_units_ff <= u_ff[31] ? (32'd0 - UNITS_MAX[31:0]) : UNITS_MAX[31:0];
                  end else begin
                     wb_units_ff <= u_ff[31] ? (32'd0 - tot[31:0]) : tot[31:0];
                  end
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               state_ff <= ST_COST;
            end
            ST_COST: begin
               if (csum[63]) begin
                  cost_ff <= COST_MAX;
                  sat_ff  <= 1'b1;
               end else begin
                  cost_ff <= csum[62:0];
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_realized_ff <= realized_ff;
                  rsp_cost_ff     <= cost_ff;
                  rsp_net_ff      <= net;
                  rsp_unreal_ff   <= unreal_ff;
                  if (drop_ff) begin
                     rsp_status_ff <= STAT_FULL;
                  end else if (sat_ff || net_ovf) begin
                     rsp_status_ff <= STAT_SAT;
                  end else begin
                     rsp_status_ff <= STAT_OK;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_realized_total   = rsp_realized_ff;
   assign rsp_cost_total       = rsp_cost_ff;
   assign rsp_net_total        = rsp_net_ff;
   assign rsp_unrealized_value = rsp_unreal_ff;
   assign rsp_status           = rsp_status_ff;

   `PLG_ASSERT(a_pop_only_idle, clock, reset, pop_o |-> (state_ff == ST_IDLE), "pop outside idle")
   `PLG_ASSERT(a_no_write_in_search, clock, reset, (state_ff == ST_SEARCH) |-> !mem_we, "table write during search")
   `PLG_ASSERT(a_div_nonzero, clock, reset, (state_ff == ST_DIV) |-> (den_ff != '0), "zero divisor")

endmodule
`default_nettype wire
